@@ rtl/core/red_spot_peak_tracker_macros.svh @@
// assertion macros for the red spot peak tracker
`ifndef RED_SPOT_PEAK_TRACKER_MACROS_SVH
`define RED_SPOT_PEAK_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define RSPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RSPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RSPT_ASSERT(label, clk, rst_n, prop)
`define RSPT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/rspt_pkg.sv @@
package rspt_pkg;
    localparam int ROW_WIDTH = 320;
    localparam int COL_LIMIT_I = (ROW_WIDTH - 1 > 511) ? 511 : ROW_WIDTH - 1;
    localparam logic [8:0] COL_LIMIT = COL_LIMIT_I[8:0];
    localparam logic [8:0] CENTER_X_RESET = 9'd159;
    localparam logic [7:0] CENTER_Y_RESET = 8'd119;
    localparam logic [0:0] REG_CENTER_X = 1'b0;
    localparam logic [0:0] REG_CENTER_Y = 1'b1;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [15:0] pixel;
        logic [7:0]  row;
        logic        last_in_row;
    } in_beat_t;

    typedef struct packed {
        logic [8:0]  best_x;
        logic [7:0]  best_y;
        logic [11:0] best_score;
        logic [12:0] distance_q4;
    } out_beat_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [8:0] sum_sv;    // sat + val
        logic [5:0] d;         // max - min, 0 marks a gray pixel
        logic [11:0] num60;    // 60 * hue numerator
        logic       red_dom;
        logic [8:0] col;
        logic [7:0] row;
        logic       last;
    } job_t;

    typedef enum logic [1:0] {
        F_TAKE, F_START, F_DIV, F_CALC
    } fstate_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_UPD, ST_SQRT, ST_OUT
    } bstate_t;
endpackage

@@ rtl/core/rspt_if.sv @@
interface rspt_in_if;
    logic             valid;
    logic             ready;
    rspt_pkg::in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rspt_out_if;
    logic              valid;
    logic              ready;
    rspt_pkg::out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rspt_divu.sv @@
// restoring divider, one quotient bit per cycle, 15-bit dividend
module rspt_divu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [14:0] dividend,
    input  logic [5:0]  divisor,
    output logic        done,
    output logic [14:0] quotient
);
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [14:0] q_reg, q_next;
    logic [6:0]  rem_reg, rem_next;
    logic [5:0]  dv_reg, dv_next;
    logic [6:0]  trial;

    always_comb
    begin
        trial = {rem_reg[5:0], q_reg[14]};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        dv_next = dv_reg;
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 4'd0;
            q_next = dividend;
            rem_next = 7'd0;
            dv_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dv_reg})
            begin
                rem_next = trial - {1'b0, dv_reg};
                q_next = {q_reg[13:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[13:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd14)
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    assign quotient = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        dv_reg <= dv_next;
    end
endmodule

@@ rtl/core/rspt_front.sv @@
`include "red_spot_peak_tracker_macros.svh"
// front: column count, rgb split and saturation/value terms
module rspt_front (
    input  logic              clk,
    input  logic              rst_n,
    rspt_in_if.sink           in_ch,
    output logic              q_push,
    output rspt_pkg::job_t    q_data,
    input  logic              q_full
);
    rspt_pkg::fstate_t  st_reg, st_next;
    logic [8:0]       col_reg, col_next;
    rspt_pkg::in_beat_t hold_reg;
    logic [4:0]       r, b;
    logic [5:0]       r6, g, b6, mx, mn, d, hue_a, hue_b;
    logic [22:0]      val_p;
    logic [8:0]       val;
    logic [14:0]      sat_num;
    logic [8:0]       sat;
    logic             div_start, div_done;
    logic [14:0]      div_q;

    assign in_ch.ready = (st_reg == rspt_pkg::F_TAKE);

    // saturation 360*d/max, one quotient bit per cycle
    rspt_divu u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(sat_num), .divisor(mx),
        .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        r = hold_reg.pixel[15:11];
        g = hold_reg.pixel[10:5];
        b = hold_reg.pixel[4:0];
        r6 = {1'b0, r};
        b6 = {1'b0, b};
        mx = r6;
        mn = r6;
        if (g > mx) mx = g;
        if (b6 > mx) mx = b6;
        if (g < mn) mn = g;
        if (b6 < mn) mn = b6;
        d = mx - mn;
        hue_a = d - (g - b6);
        hue_b = b6 - g;
        // max*366/255 by reciprocal multiply, exact for max below 64
        val_p = {17'd0, mx} * 23'd94064;
        val = {2'b0, val_p[22:16]};
        sat_num = {9'd0, d} * 15'd360;
        sat = (mx == 6'd0) ? 9'd0 : div_q[8:0];
    end

    always_comb
    begin
        q_data.col = col_reg;
        q_data.row = hold_reg.row;
        q_data.last = hold_reg.last_in_row;
        q_data.red_dom = (d != 6'd0) && (mx == r6);
        q_data.d = d;
        q_data.num60 = (g >= b6) ? {6'd0, hue_a} * 12'd60 : {6'd0, hue_b} * 12'd60;
        q_data.sum_sv = sat + val;
        if (d == 6'd0)
            q_data.num60 = 12'd0;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            rspt_pkg::F_TAKE: if (in_ch.valid) st_next = rspt_pkg::F_START;
            rspt_pkg::F_START: st_next = rspt_pkg::F_DIV;
            rspt_pkg::F_DIV: if (div_done) st_next = rspt_pkg::F_CALC;
            rspt_pkg::F_CALC: if (!q_full) st_next = rspt_pkg::F_TAKE;
            default: st_next = rspt_pkg::F_TAKE;
        endcase
    end

    always_comb
    begin
        q_push = (st_reg == rspt_pkg::F_CALC) && !q_full;
        div_start = (st_reg == rspt_pkg::F_START);
        col_next = col_reg;
        if (q_push)
        begin
            if (hold_reg.last_in_row)
                col_next = 9'd0;
            else if (col_reg < rspt_pkg::COL_LIMIT)
                col_next = col_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= rspt_pkg::F_TAKE;
            col_reg <= 9'd0;
        end
        else
        begin
            st_reg <= st_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            hold_reg <= in_ch.data;
    end

    `RSPT_ASSERT(a_col_limit, clk, rst_n, col_reg <= rspt_pkg::COL_LIMIT)
    `RSPT_ASSERT(a_push_calc, clk, rst_n, q_push |-> st_reg == rspt_pkg::F_CALC)
    `RSPT_ASSERT(a_take_then_start, clk, rst_n, (in_ch.valid && in_ch.ready) |=> st_reg == rspt_pkg::F_START)
endmodule

@@ rtl/core/rspt_queue.sv @@
`include "red_spot_peak_tracker_macros.svh"
// two-entry job queue between front and back
module rspt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rspt_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rspt_pkg::job_t pop_data
);
    rspt_pkg::job_t mem_reg [rspt_pkg::QDEPTH];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    `RSPT_ASSERT(a_no_overflow, clk, rst_n, push |-> !full)
    `RSPT_ASSERT(a_no_underflow, clk, rst_n, pop |-> !empty)
    `RSPT_ASSERT(a_cnt_range, clk, rst_n, cnt_reg != 2'd3)
endmodule

@@ rtl/core/rspt_back.sv @@
`include "red_spot_peak_tracker_macros.svh"
// back: hue divide, maximum update, distance root, result register
module rspt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  rspt_pkg::job_t job,
    output logic           q_pop,
    input  logic [8:0]     center_x,
    input  logic [7:0]     center_y,
    rspt_out_if.source     out_ch
);
    rspt_pkg::bstate_t st_reg, st_next;
    rspt_pkg::job_t    job_reg;
    logic [11:0]       top_score_reg;
    logic [8:0]        top_col_reg;
    logic [7:0]        top_row_reg;
    logic              div_start, div_done;
    logic [14:0]       div_q;
    logic [11:0]       hw_reg;
    logic [11:0]       score;
    logic              upd_hit;
    logic [8:0]        col_cur;
    logic [7:0]        row_cur;
    logic [9:0]        dx, dy;
    logic [9:0]        adx, ady;
    logic [19:0]       sqx, sqy, d2;
    logic [27:0]       rad_reg;
    logic [27:0]       res_reg;
    logic [27:0]       bit_reg;
    logic [27:0]       trial;
    logic              valid_reg;
    rspt_pkg::out_beat_t obuf_reg;

    // operands come straight from the queue head, latched at the pop
    rspt_divu u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend({3'd0, job.num60}), .divisor(job.d),
        .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            rspt_pkg::ST_IDLE: if (!q_empty) st_next = rspt_pkg::ST_DIV;
            rspt_pkg::ST_DIV:
                if (!job_reg.red_dom || div_done) st_next = rspt_pkg::ST_UPD;
            rspt_pkg::ST_UPD:
                if (job_reg.last) st_next = rspt_pkg::ST_SQRT;
                else st_next = rspt_pkg::ST_IDLE;
            rspt_pkg::ST_SQRT: if (bit_reg == 28'd0) st_next = rspt_pkg::ST_OUT;
            rspt_pkg::ST_OUT: if (!valid_reg) st_next = rspt_pkg::ST_IDLE;
            default: st_next = rspt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (st_reg == rspt_pkg::ST_IDLE) && !q_empty;
        div_start = q_pop;
        score = 12'(hw_reg * 7'd60) + {3'd0, job_reg.sum_sv};
        // distance uses the position as it stands after this update
        upd_hit = (st_reg == rspt_pkg::ST_UPD) && (score > top_score_reg);
        col_cur = upd_hit ? job_reg.col : top_col_reg;
        row_cur = upd_hit ? job_reg.row : top_row_reg;
        dx = {1'b0, col_cur} - {1'b0, center_x};
        dy = {2'b0, row_cur} - {2'b0, center_y};
        adx = dx[9] ? 10'(-dx) : dx;
        ady = dy[9] ? 10'(-dy) : dy;
        sqx = {10'd0, adx} * {10'd0, adx};
        sqy = {10'd0, ady} * {10'd0, ady};
        d2 = sqx + sqy;
        trial = res_reg + bit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= rspt_pkg::ST_IDLE;
            top_score_reg <= 12'd0;
            top_col_reg <= 9'd0;
            top_row_reg <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (upd_hit)
            begin
                top_score_reg <= score;
                top_col_reg <= job_reg.col;
                top_row_reg <= job_reg.row;
            end
            if (valid_reg && out_ch.ready)
                valid_reg <= 1'b0;
            else if (st_reg == rspt_pkg::ST_OUT && !valid_reg)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= job;
        if (st_reg == rspt_pkg::ST_DIV)
            hw_reg <= !job_reg.red_dom ? ((job_reg.d == 6'd0) ? 12'd60 : 12'd0) : div_q[11:0];
        if (st_reg == rspt_pkg::ST_UPD)
        begin
            // radicand is 256 * squared distance
            rad_reg <= {d2, 8'd0};
            res_reg <= 28'd0;
            bit_reg <= 28'd1 << 26;
        end
        else if (st_reg == rspt_pkg::ST_SQRT && bit_reg != 28'd0)
        begin
            if (rad_reg >= trial)
            begin
                rad_reg <= rad_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (st_reg == rspt_pkg::ST_OUT && !valid_reg)
        begin
            obuf_reg.best_x <= top_col_reg;
            obuf_reg.best_y <= top_row_reg;
            obuf_reg.best_score <= top_score_reg;
            obuf_reg.distance_q4 <= (res_reg > 28'd8191) ? 13'h1FFF : res_reg[12:0];
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.data = obuf_reg;

    `RSPT_ASSERT(a_hold_out, clk, rst_n, (valid_reg && !out_ch.ready) |=> valid_reg)
    `RSPT_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> st_reg == rspt_pkg::ST_IDLE)
    `RSPT_ASSERT(a_score_range, clk, rst_n, top_score_reg <= 12'd4050)
endmodule

@@ rtl/core/red_spot_peak_tracker.sv @@
// a row-end beat passes the front, the queue and the back's hue divide, update,
// distance root and output states before its result beat; the back does not
// wait for the hue divide when that pixel is not red dominant; the front takes a
// new pixel only once the last is pushed, and a 2-entry queue decouples the two
// reset: asynchronous active low; best position/score and column count clear,
// centre registers return to (159, 119)
module red_spot_peak_tracker (
    input  logic       clk,
    input  logic       rst_n,
    rspt_in_if.sink    in_ch,
    rspt_out_if.source out_ch,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [8:0] cfg_data
);
    // centre point registers
    logic [8:0]     center_x_reg;
    logic [7:0]     center_y_reg;
    // queue handshake between front and back
    logic           q_push, q_full, q_pop, q_empty;
    rspt_pkg::job_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= rspt_pkg::CENTER_X_RESET;
            center_y_reg <= rspt_pkg::CENTER_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rspt_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                rspt_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front: takes a pixel beat, splits rgb, builds the job
    rspt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    // short queue so front and back stall independently
    rspt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );

    // back: finishes score, tracks the peak, emits row-end result beats
    rspt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .job(q_out), .q_pop(q_pop),
        .center_x(center_x_reg), .center_y(center_y_reg), .out_ch(out_ch)
    );
endmodule
